/* rtl/sorted_table_binary_search_assert.svh */
// Assertion macros for the sorted key table.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define STBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define STBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define STBS_ASSERT(lbl, prop, msg)
`define STBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/stbs_pkg.sv */
package stbs_pkg;

    localparam int KEY_W      = 32;
    localparam int KIND_W     = 2;
    localparam int POS_W      = 7;
    localparam int ECNT_W     = 8;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

endpackage

/* rtl/sorted_table_binary_search.sv */
// Insert walks down from the top entry, moving larger keys up, s keys moved (0..count);
//   query makes p midpoint probes (1..log2(TABLE_DEPTH)+1, 8 at depth 128);
//   clear, unused kind, refused insert, insert into an empty table and query of an
//   empty table go straight to the result.
// Throughput: one item at a time, bounded by the single read and write port of the key RAM.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending result beat;
//   the key RAM itself is not cleared, only entries below the count are ever read.
`include "sorted_table_binary_search_assert.svh"

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side: tuser = kind[1:0]; tdata = key_value[31:0]
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [stbs_pkg::KIND_W-1:0]         i_s_tuser,
    input  logic [stbs_pkg::KEY_W-1:0]          i_s_tdata,
    // master side: tdata = found[0], position[7:1], entry_count[15:8],
    //              refused[16], zero fill[23:17]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [stbs_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);     // key RAM address
    localparam int CW = $clog2(TABLE_DEPTH + 1); // count 0..TABLE_DEPTH

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,  // walking down, moving larger keys up by one
        S_PUT  = 5'b00100,  // key lands at entry 0
        S_QRY  = 5'b01000,  // one midpoint probe per cycle
        S_OUT  = 5'b10000   // hand result to the output register
    } t_state;

    // key RAM: one write port, one registered read port
    logic signed [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [stbs_pkg::KEY_W-1:0] r_rdata;
    logic [AW-1:0]                     rd_addr;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [stbs_pkg::KEY_W-1:0] wr_data;

    t_state                            r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic signed [stbs_pkg::KEY_W-1:0] r_key, n_key;
    logic [AW-1:0]                     r_idx, n_idx;   // insert slot under test
    logic [CW-1:0]                     r_lo, n_lo;     // search window [lo, hi)
    logic [CW-1:0]                     r_hi, n_hi;
    logic [AW-1:0]                     r_mid, n_mid;   // address probed last cycle
    logic                              r_found, n_found;
    logic                              r_refused, n_refused;

    logic                              r_out_valid;
    logic [stbs_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic                              s_acc;
    logic                              out_free;
    logic                              key_eq;
    logic                              key_lt;
    logic                              key_gt;
    logic [CW-1:0]                     q_lo;
    logic [CW-1:0]                     q_hi;
    logic [CW:0]                       q_sum;
    logic [CW:0]                       first_sum;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign key_eq = (r_rdata == r_key);
    assign key_lt = (r_rdata < r_key);
    assign key_gt = (r_rdata > r_key);

    // next search window after a miss; C-style mid = (lo + hi_incl) / 2
    assign q_lo      = key_lt ? (CW'(r_mid) + CW'(1)) : r_lo;
    assign q_hi      = key_lt ? r_hi : CW'(r_mid);
    assign q_sum     = (CW+1)'(q_lo) + (CW+1)'(q_hi) - (CW+1)'(1);
    assign first_sum = (CW+1)'(r_count) - (CW+1)'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_found   = r_found;
        n_refused = r_refused;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = r_key;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_key     = i_s_tdata;
                    n_found   = 1'b0;
                    n_refused = 1'b0;
                    n_mid     = '0;
                    n_state   = S_OUT;
                    case (i_s_tuser)
                        stbs_pkg::KIND_INSERT: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_refused = 1'b1;
                            end else if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = i_s_tdata;
                                n_count = r_count + CW'(1);
                            end else begin
                                rd_addr = AW'(r_count - CW'(1));
                                n_idx   = AW'(r_count);
                                n_state = S_INS;
                            end
                        end
                        stbs_pkg::KIND_QUERY: begin
                            if (r_count != '0) begin
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_mid   = AW'(first_sum >> 1);
                                rd_addr = AW'(first_sum >> 1);
                                n_state = S_QRY;
                            end
                        end
                        stbs_pkg::KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // r_rdata holds entry r_idx-1. Writes go to r_idx while the next
            // read is r_idx-2, so the ports never meet on one entry.
            S_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                if (key_gt) begin
                    wr_data = r_rdata;
                    n_idx   = r_idx - AW'(1);
                    if (r_idx == AW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_addr = r_idx - AW'(2);
                    end
                end else begin
                    wr_data = r_key;
                    n_count = r_count + CW'(1);
                    n_state = S_OUT;
                end
            end

            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_key;
                n_count = r_count + CW'(1);
                n_state = S_OUT;
            end

            S_QRY: begin
                if (key_eq) begin
                    n_found = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_lo    = q_lo;
                    n_hi    = q_hi;
                    if (q_lo < q_hi) begin
                        n_mid   = AW'(q_sum >> 1);
                        rd_addr = AW'(q_sum >> 1);
                    end else begin
                        n_mid   = '0;
                        n_state = S_OUT;
                    end
                end
            end

            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_found   <= n_found;
        r_refused <= n_refused;
    end

    // output register: frees the sequencer while a result beat waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_data <= {7'b0, r_refused, stbs_pkg::ECNT_W'(r_count),
                           stbs_pkg::POS_W'(r_mid), r_found};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `STBS_ASSERT(a_count_in_range, r_count <= CW'(TABLE_DEPTH), "key count beyond table depth")
    `STBS_ASSERT(a_refuse_only_full, (r_state == S_OUT && r_refused) |-> (r_count == CW'(TABLE_DEPTH)), "insert refused with room left")
    `STBS_ASSERT(a_put_grows, (r_state == S_PUT) |=> (r_count == $past(r_count) + CW'(1)), "insert at entry 0 did not grow the table")
    `STBS_ASSERT(a_window_open, (r_state == S_QRY) |-> (r_lo < r_hi && CW'(r_mid) < r_hi && CW'(r_mid) >= r_lo), "probe outside search window")
    `STBS_ASSERT(a_hit_in_table, (r_state == S_OUT && r_found) |-> (CW'(r_mid) < r_count), "hit reported beyond occupied entries")
    `STBS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "sequencer not idle after reset")

endmodule

/* bench/tb_sorted_table_binary_search.sv */
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;

    localparam int TABLE_DEPTH = 128;
    // kind code that the block treats as a no-op
    localparam logic [stbs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    // long receiver hold-off, and quiet-cycle limit for the watchdog
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    // worst insert moves 127 keys, so settle well beyond the time that takes
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [stbs_pkg::KIND_W-1:0]       kind;
        logic signed [stbs_pkg::KEY_W-1:0] key;
    } t_table_op;

    typedef struct {
        logic                        found;
        logic [stbs_pkg::POS_W-1:0]  position;
        logic [stbs_pkg::ECNT_W-1:0] entry_count;
        logic                        refused;
    } t_table_answer;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [stbs_pkg::KIND_W-1:0]     i_s_tuser  = '0;   // kind[1:0]
    logic [stbs_pkg::KEY_W-1:0]      i_s_tdata  = '0;   // key_value[31:0]
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // found[0], position[7:1], entry_count[15:8], refused[16], zero fill[23:17]
    logic [stbs_pkg::OUT_DATA_W-1:0] o_m_tdata;

    // mirror of the block's table
    logic signed [stbs_pkg::KEY_W-1:0] keys_held [TABLE_DEPTH];
    int                                held_count = 0;

    t_table_op                         ops_to_send [$];
    t_table_answer                     answers_due [$];
    logic signed [stbs_pkg::KEY_W-1:0] gen_keys [$];   // keys the generator believes are stored
    int                                queued_count = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;

    t_table_op     next_op;
    t_table_answer got_answer;
    t_table_answer want_answer;

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one operation to the mirrored table and returns the answer beat it should give.
    function automatic t_table_answer apply_table_op(input t_table_op op);
        t_table_answer ans;
        int            slot;
        int            lo;
        int            hi;
        int            mid;
        ans = '{1'b0, '0, '0, 1'b0};
        case (op.kind)
            stbs_pkg::KIND_INSERT: begin
                if (held_count >= TABLE_DEPTH) begin
                    ans.refused = 1'b1;
                end else begin
                    // shift larger keys up one place; equal keys stay below the new one
                    slot = held_count;
                    while (slot > 0 && keys_held[slot-1] > op.key) begin
                        keys_held[slot] = keys_held[slot-1];
                        slot--;
                    end
                    keys_held[slot] = op.key;
                    held_count++;
                end
            end
            stbs_pkg::KIND_QUERY: begin
                lo = 0;
                hi = held_count - 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (keys_held[mid] == op.key) begin
                        ans.found    = 1'b1;
                        ans.position = stbs_pkg::POS_W'(mid);
                        break;
                    end
                    if (keys_held[mid] < op.key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
            end
            stbs_pkg::KIND_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        ans.entry_count = stbs_pkg::ECNT_W'(held_count);
        return ans;
    endfunction

    // mode 0: full 32-bit range, 1: tight range full of duplicates, 2: moderate range
    function automatic logic signed [stbs_pkg::KEY_W-1:0] draw_key(input int mode);
        case (mode)
            0:       return $urandom;
            1:       return int'($urandom_range(0, 15)) - 8;
            default: return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic push_op(input logic [stbs_pkg::KIND_W-1:0] kind,
                           input logic signed [stbs_pkg::KEY_W-1:0] key);
        ops_to_send.push_back('{kind, key});
        queued_count++;
        if (kind == stbs_pkg::KIND_INSERT && gen_keys.size() < TABLE_DEPTH) begin
            gen_keys.push_back(key);
        end else if (kind == stbs_pkg::KIND_CLEAR) begin
            gen_keys.delete();
        end
    endtask

    // Clear (9 in 10 if no fill), inserts, then mostly queries of stored keys with some noise.
    task automatic add_sequence(input bit fill);
        int                                n;
        int                                mode;
        int                                pick;
        logic signed [stbs_pkg::KEY_W-1:0] k;
        mode = $urandom_range(2);
        if (fill || $urandom_range(9) != 0) begin
            push_op(stbs_pkg::KIND_CLEAR, $urandom);
        end
        // a fill runs past the table depth so that some inserts are refused
        n = fill ? TABLE_DEPTH + $urandom_range(1, 4) : $urandom_range(1, 40);
        repeat (n) push_op(stbs_pkg::KIND_INSERT, draw_key(mode));
        repeat ($urandom_range(5, 25)) begin
            pick = $urandom_range(99);
            if (pick < 55 && gen_keys.size() != 0) begin
                k = gen_keys[$urandom_range(gen_keys.size() - 1)];
            end else if (pick < 75 && gen_keys.size() != 0) begin
                k = gen_keys[$urandom_range(gen_keys.size() - 1)] + ($urandom_range(1) ? 1 : -1);
            end else begin
                k = draw_key(mode);
            end
            if (pick >= 97) begin
                push_op(KIND_UNUSED, k);
            end else if (pick == 96) begin
                push_op(stbs_pkg::KIND_CLEAR, k);
            end else if (pick >= 86) begin
                push_op(stbs_pkg::KIND_INSERT, k);
            end else begin
                push_op(stbs_pkg::KIND_QUERY, k);
            end
        end
    endtask

    // Sender pause: nothing more is offered until every answer has come back.
    task automatic wait_drained();
        while (ops_to_send.size() != 0 || i_s_tvalid || answers_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int items,
                             input bit with_hold);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = queued_count;
        if (with_hold) begin
            hold_requests++;
        end
        add_sequence(1'b1);
        while (queued_count - start < items) begin
            add_sequence(1'b0);
        end
        wait_drained();
    endtask

    // Driver: offers the next op when the slave side is free, idling at random; the accepted
    // beat feeds the table mirror.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                answers_due.push_back(apply_table_op('{i_s_tuser, i_s_tdata}));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_op = ops_to_send.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= next_op.kind;
                    i_s_tdata  <= next_op.key;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen  <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: each answer beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_answer = '{o_m_tdata[0], o_m_tdata[7:1], o_m_tdata[15:8], o_m_tdata[16]};
            if (answers_due.size() == 0) begin
                report_error($sformatf("answer beat with nothing outstanding: %h", o_m_tdata));
            end else begin
                want_answer = answers_due.pop_front();
                if (got_answer.found !== want_answer.found)
                    report_error($sformatf("found %b, want %b",
                                           got_answer.found, want_answer.found));
                if (got_answer.position !== want_answer.position)
                    report_error($sformatf("position %0d, want %0d",
                                           got_answer.position, want_answer.position));
                if (got_answer.entry_count !== want_answer.entry_count)
                    report_error($sformatf("entry_count %0d, want %0d",
                                           got_answer.entry_count, want_answer.entry_count));
                if (got_answer.refused !== want_answer.refused)
                    report_error($sformatf("refused %b, want %b",
                                           got_answer.refused, want_answer.refused));
                if (o_m_tdata[stbs_pkg::OUT_DATA_W-1:17] !== '0)
                    report_error($sformatf("zero fill not zero: %h", o_m_tdata));
            end
        end
    end

    // Watchdog: counts cycles with work outstanding but no beat moving on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (ops_to_send.size() == 0 && !i_s_tvalid && answers_due.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, field extremes, duplicates, misses, unused kind, clear
        send_idle_pct = 11;
        recv_idle_pct = 85;
        push_op(stbs_pkg::KIND_QUERY,  32'sd0);
        push_op(stbs_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
        push_op(stbs_pkg::KIND_INSERT, 32'sh8000_0000);
        push_op(stbs_pkg::KIND_INSERT, 32'sd0);
        push_op(stbs_pkg::KIND_INSERT, -32'sd1);
        push_op(stbs_pkg::KIND_INSERT, 32'sd0);
        push_op(stbs_pkg::KIND_INSERT, 32'sd1);
        push_op(stbs_pkg::KIND_QUERY,  32'sh8000_0000);
        push_op(stbs_pkg::KIND_QUERY,  32'sh7FFF_FFFF);
        push_op(stbs_pkg::KIND_QUERY,  32'sd0);
        push_op(stbs_pkg::KIND_QUERY,  -32'sd1);
        push_op(stbs_pkg::KIND_QUERY,  32'sd1);
        push_op(stbs_pkg::KIND_QUERY,  32'sd2);
        push_op(stbs_pkg::KIND_QUERY,  32'sh8000_0001);
        push_op(KIND_UNUSED,           32'sh7FFF_FFFF);
        push_op(stbs_pkg::KIND_CLEAR,  32'shFFFF_FFFF);
        push_op(stbs_pkg::KIND_QUERY,  32'sd0);
        push_op(stbs_pkg::KIND_INSERT, 32'sd7);
        push_op(stbs_pkg::KIND_QUERY,  32'sd7);
        push_op(KIND_UNUSED,           32'sd0);
        push_op(stbs_pkg::KIND_CLEAR,  32'sd0);
        wait_drained();

        run_phase(11, 85, 600, 1'b0);
        run_phase(85, 11, 600, 1'b0);
        // no idling; the receiver holds off at the start so the block backs up its input
        run_phase(0, 0, 600, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            report_error($sformatf("%0d answers never arrived", answers_due.size()));
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
